@@ sv/rld_pkg.sv @@
// Types, codes and character classes for the block run-length decoder.
// No dependencies; used by block_run_length_decoder and rld_checker.
package rld_pkg;

	localparam int MAX_BLOCK  = 8;
	localparam int MAX_REPEAT = 64;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = 7;
	localparam int ACC_W      = 10;
	localparam int IDX_W      = 3;
	localparam int REP_W      = 6;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;
	localparam logic [1:0] ST_BIG     = 2'd3;

	// decoder phase; after an error it holds the status code
	localparam logic [1:0] PH_PASS  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_FILL  = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_BLOCK_LENGTH = 1'b0;
	localparam logic REG_MULTI_DIGIT  = 1'b1;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [7:0]       lane_0;
		logic [7:0]       lane_1;
		logic [7:0]       lane_2;
		logic [7:0]       lane_3;
		logic [7:0]       lane_4;
		logic [7:0]       lane_5;
		logic [7:0]       lane_6;
		logic [7:0]       lane_7;
		logic [LEN_W-1:0] bytes_valid;
		logic [1:0]       status;
		logic             finished;
		logic             last_of_run;
	} res_item_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// printable or whitespace
	function automatic logic is_text(input logic [7:0] c);
		return c inside {[8'h20:8'h7E], [8'h09:8'h0D]};
	endfunction

endpackage

@@ sv/block_run_length_decoder.sv @@
// Block run-length decoder: top level with APB register port and sequencer.
// Depends on rld_pkg.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   text     | in        | text_valid / text_ready   | text_item (rld_pkg::text_item_t)
//   res      | out       | res_valid / res_ready     | res_item  (rld_pkg::res_item_t)
//   apb      | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One byte per transaction; text_ready is high only while the sequencer idles.
// A pass-through byte, end of text or byte error is accepted, decoded and output.
// A count digit is accepted and decoded; a further decimal digit then makes two
// passes of the adder, plus output when it takes the count over the limit.
// The last byte of a block is decoded, then gives out one copy per cycle while the
// output register is free; the one 10-bit adder is shared by count accumulation
// and the copy counter. Reset clears control state; the block store has no reset.
// A stalled output register holds the sequencer in its output state.
module block_run_length_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  rld_pkg::text_item_t    text_item,
	output logic                   res_valid,
	input  logic                   res_ready,
	output rld_pkg::res_item_t     res_item
);
	import rld_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_MUL1 = 6'b000100,
		S_MUL2 = 6'b001000,
		S_EMIT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] block_length_q;
	logic             multi_digit_q;
	logic [7:0]       byte_q;
	logic             eot_q;
	logic [1:0]       phase_q;
	logic             failed_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] fill_q;
	logic [REP_W-1:0] rep_q;
	logic [8:0]       acc_q;
	logic [7:0]       store_q [MAX_BLOCK];
	res_item_t        pend_q;
	res_item_t        res_item_q;
	logic             res_valid_q;

	logic             cfg_wr;
	logic [LEN_W-1:0] eff_len;
	logic             dig;
	logic             txt;
	logic [7:0]       dig_diff;
	logic [3:0]       digit;
	logic             slot_free;
	logic             res_load;
	logic [ACC_W-1:0] add_a;
	logic [ACC_W-1:0] add_b;
	logic [ACC_W-1:0] add_sum;
	logic             last_copy;
	logic [LEN_W-1:0] idx;
	logic [LEN_W-1:0] fill_inc;
	logic             block_done;
	logic             do_fail;
	logic [1:0]       fail_code;
	logic             do_fin;
	logic             do_pass;
	logic             do_store;
	logic             start_count;
	logic             mul_go;
	res_item_t        pend_next;
	res_item_t        big_item;
	res_item_t        blk_item;
	logic [7:0]       lane_v [MAX_BLOCK];

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= LEN_W'(1);
			multi_digit_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_BLOCK_LENGTH: block_length_q <= pwdata[LEN_W-1:0];
				REG_MULTI_DIGIT:  multi_digit_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				REG_BLOCK_LENGTH: prdata = {{(32-LEN_W){1'b0}}, block_length_q};
				REG_MULTI_DIGIT:  prdata = {31'b0, multi_digit_q};
				default:          prdata = '0;
			endcase
		end
	end

	// length 0 acts as 1, above MAX_BLOCK clamps
	always_comb begin
		if (block_length_q == '0)
			eff_len = LEN_W'(1);
		else if (block_length_q > LEN_W'(MAX_BLOCK))
			eff_len = LEN_W'(MAX_BLOCK);
		else
			eff_len = block_length_q;
	end

	// ---------------- decode ----------------
	assign text_ready = (state_q == S_IDLE);
	assign slot_free  = !res_valid_q || res_ready;
	assign res_load   = slot_free && (state_q == S_EMIT || state_q == S_OUT);
	assign dig        = is_digit(byte_q);
	assign txt        = is_text(byte_q);
	assign dig_diff   = byte_q - CHAR_ZERO;
	assign digit      = dig_diff[3:0];

	// a block starts at entry 0 when the count phase ends
	assign idx        = (phase_q == PH_COUNT) ? '0 : fill_q;
	assign fill_inc   = idx + LEN_W'(1);
	assign block_done = (fill_inc >= eff_len);

	always_comb begin
		do_fail     = 1'b0;
		fail_code   = ST_OK;
		do_fin      = 1'b0;
		do_pass     = 1'b0;
		do_store    = 1'b0;
		start_count = 1'b0;
		mul_go      = 1'b0;
		if (failed_q) begin
			do_fail   = 1'b1;
			fail_code = phase_q;
		end else if (eot_q) begin
			if (phase_q != PH_PASS) begin
				do_fail   = 1'b1;
				fail_code = ST_TRUNC;
			end else begin
				do_fin = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_PASS: begin
					if (dig) begin
						start_count = 1'b1;
					end else if (!txt) begin
						do_fail   = 1'b1;
						fail_code = ST_INVALID;
					end else begin
						do_pass = 1'b1;
					end
				end
				PH_COUNT: begin
					if (dig) begin
						mul_go = 1'b1;
					end else if (!txt) begin
						do_fail   = 1'b1;
						fail_code = ST_INVALID;
					end else begin
						do_store = 1'b1;
					end
				end
				default: begin
					if (dig || !txt) begin
						do_fail   = 1'b1;
						fail_code = ST_INVALID;
					end else begin
						do_store = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		pend_next = '0;
		pend_next.last_of_run = 1'b1;
		if (do_fail) begin
			pend_next.status = fail_code;
		end else if (do_fin) begin
			pend_next.finished = 1'b1;
		end else begin
			pend_next.lane_0      = byte_q;
			pend_next.bytes_valid = LEN_W'(1);
		end
	end

	always_comb begin
		big_item             = '0;
		big_item.status      = ST_BIG;
		big_item.last_of_run = 1'b1;
	end

	// ---------------- shared adder ----------------
	// count*10 + d as (5*count)*2 + d over two passes; copy counter otherwise
	always_comb begin
		case (state_q)
			S_MUL1: begin
				add_a = {{(ACC_W-CNT_W){1'b0}}, count_q};
				add_b = {{(ACC_W-CNT_W-2){1'b0}}, count_q, 2'b00};
			end
			S_MUL2: begin
				add_a = {acc_q, 1'b0};
				add_b = {{(ACC_W-4){1'b0}}, digit};
			end
			S_EMIT: begin
				add_a = {{(ACC_W-REP_W){1'b0}}, rep_q};
				add_b = ACC_W'(1);
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end
	assign add_sum   = add_a + add_b;
	assign last_copy = (add_sum == {{(ACC_W-CNT_W){1'b0}}, count_q});

	// lanes at or above the block length read as zero
	always_comb begin
		for (int j = 0; j < MAX_BLOCK; j++)
			lane_v[j] = (LEN_W'(j) < eff_len) ? store_q[j] : 8'h00;
	end

	always_comb begin
		blk_item             = '0;
		blk_item.lane_0      = lane_v[0];
		blk_item.lane_1      = lane_v[1];
		blk_item.lane_2      = lane_v[2];
		blk_item.lane_3      = lane_v[3];
		blk_item.lane_4      = lane_v[4];
		blk_item.lane_5      = lane_v[5];
		blk_item.lane_6      = lane_v[6];
		blk_item.lane_7      = lane_v[7];
		blk_item.bytes_valid = eff_len;
		blk_item.last_of_run = last_copy;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_PASS;
			failed_q    <= 1'b0;
			count_q     <= '0;
			fill_q      <= '0;
			rep_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (text_valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (do_fail) begin
						failed_q <= 1'b1;
						phase_q  <= fail_code;
						state_q  <= S_OUT;
					end else if (do_fin || do_pass) begin
						state_q <= S_OUT;
					end else if (start_count) begin
						count_q <= CNT_W'(digit);
						fill_q  <= '0;
						phase_q <= multi_digit_q ? PH_COUNT : PH_FILL;
						state_q <= S_IDLE;
					end else if (mul_go) begin
						state_q <= S_MUL1;
					end else if (do_store) begin
						if (block_done) begin
							fill_q  <= '0;
							phase_q <= PH_PASS;
							rep_q   <= '0;
							state_q <= (count_q == '0) ? S_IDLE : S_EMIT;
						end else begin
							fill_q  <= fill_inc;
							phase_q <= PH_FILL;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					if (add_sum > ACC_W'(MAX_REPEAT)) begin
						failed_q <= 1'b1;
						phase_q  <= ST_BIG;
						state_q  <= S_OUT;
					end else begin
						count_q <= add_sum[CNT_W-1:0];
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						rep_q <= add_sum[REP_W-1:0];
						if (last_copy) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && text_valid) begin
			byte_q <= text_item.text_byte;
			eot_q  <= text_item.end_of_text;
		end
		if (state_q == S_EVAL) begin
			pend_q <= pend_next;
			if (do_store && idx < LEN_W'(MAX_BLOCK))
				store_q[idx[IDX_W-1:0]] <= byte_q;
		end
		if (state_q == S_MUL1)
			acc_q <= add_sum[8:0];
		if (state_q == S_MUL2 && add_sum > ACC_W'(MAX_REPEAT))
			pend_q <= big_item;
		if (state_q == S_EMIT && slot_free)
			res_item_q <= blk_item;
		if (state_q == S_OUT && slot_free)
			res_item_q <= pend_q;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

@@ sv/rld_checker.sv @@
// Port-level checks for block_run_length_decoder, attached by bind.
// Depends on rld_pkg.
module rld_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_valid,
	input logic               text_ready,
	input logic               res_valid,
	input logic               res_ready,
	input rld_pkg::res_item_t res_item
);
	import rld_pkg::*;

	// output register holds under backpressure
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// one byte in flight at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready |=> !text_ready)
		else $error("second byte taken while busy");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status != ST_OK |->
			res_item.bytes_valid == '0 && res_item.last_of_run && !res_item.finished)
		else $error("malformed error result");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.bytes_valid <= LEN_W'(MAX_BLOCK))
		else $error("bytes_valid above block limit");

	a_empty_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.bytes_valid == '0 |->
			res_item.lane_0 == 8'h00 && res_item.lane_7 == 8'h00)
		else $error("lanes set on empty result");

endmodule

bind block_run_length_decoder rld_checker u_rld_checker (.*);
